FILE: hw/rtl/nfarm_pkg.sv
// shared types, codes and constants of the nfa regex matcher
package nfarm_pkg;

  // default number of nfa states
  localparam int NFARM_MAX_STATES = 32;

  // field widths
  localparam int NFARM_CMD_W   = 2;
  localparam int NFARM_IDX_W   = 5;
  localparam int NFARM_SUCC_W  = 6;
  localparam int NFARM_BYTE_W  = 8;
  localparam int NFARM_ROW_W   = 32;
  localparam int NFARM_DATA_W  = 32;
  localparam int NFARM_PADDR_W = 4;

  // one class row per byte value
  localparam int NFARM_BYTE_VALUES = 256;

  // register indexes on the configuration port
  localparam logic [1:0] REG_ENTRY    = 2'd0;
  localparam logic [1:0] REG_ACCEPT   = 2'd1;
  localparam logic [1:0] REG_ANCHORED = 2'd2;

  // input commands
  typedef enum logic [NFARM_CMD_W-1:0] {
    CMD_WR_STATE = 2'd0,
    CMD_WR_CLASS = 2'd1,
    CMD_SUBJECT  = 2'd2,
    CMD_EMPTY    = 2'd3
  } nfarm_cmd_t;

  // state kinds
  typedef enum logic [1:0] {
    KIND_CONSUME = 2'd0,
    KIND_EPSILON = 2'd1,
    KIND_BEGIN   = 2'd2,
    KIND_END     = 2'd3
  } nfarm_kind_t;

  // one state descriptor as read from the table
  typedef struct packed {
    nfarm_kind_t             kind;
    logic [NFARM_SUCC_W-1:0] first;
    logic [NFARM_SUCC_W-1:0] second;
  } nfarm_desc_t;

  // controls of the shared expand unit
  typedef struct packed {
    logic consume_mode;
    logic pos_zero;
    logic at_end;
  } nfarm_xctl_t;

endpackage

FILE: hw/rtl/nfarm_ram.sv
// generic single-port-write ram with registered read
module nfarm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/nfarm_desc.sv
// state descriptor table: kind, successors and negate flag per state
module nfarm_desc #(
  parameter int MAX_STATES = nfarm_pkg::NFARM_MAX_STATES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [nfarm_pkg::NFARM_IDX_W-1:0]    wr_idx,
  input  nfarm_pkg::nfarm_kind_t               wr_kind,
  input  logic [nfarm_pkg::NFARM_SUCC_W-1:0]   wr_first,
  input  logic [nfarm_pkg::NFARM_SUCC_W-1:0]   wr_second,
  input  logic                                 wr_negate,
  input  logic [$clog2(MAX_STATES)-1:0]        rd_idx,
  output nfarm_pkg::nfarm_desc_t               rd_desc,
  output logic [MAX_STATES-1:0]                consume_mask,
  output logic [MAX_STATES-1:0]                negate_mask
);

  import nfarm_pkg::*;

  localparam int IW = $clog2(MAX_STATES);

  nfarm_kind_t             kind_r   [MAX_STATES];
  logic [NFARM_SUCC_W-1:0] first_r  [MAX_STATES];
  logic [NFARM_SUCC_W-1:0] second_r [MAX_STATES];
  logic [MAX_STATES-1:0]   negate_r;
  logic                    in_range;
  logic [IW-1:0]           widx;

  // writes beyond the state count are dropped
  assign in_range = int'(wr_idx) < MAX_STATES;
  assign widx     = IW'(wr_idx);

  // descriptor storage, no reset on the table itself
  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      kind_r[widx]   <= wr_kind;
      first_r[widx]  <= wr_first;
      second_r[widx] <= wr_second;
    end
  end

  // negate mask resets to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_r <= '0;
    end else if (wr_en && in_range) begin
      negate_r[widx] <= wr_negate;
    end
  end

  // single read port for the expand unit
  assign rd_desc.kind   = kind_r[rd_idx];
  assign rd_desc.first  = first_r[rd_idx];
  assign rd_desc.second = second_r[rd_idx];

  // per-state consume flags
  always_comb begin
    for (int s = 0; s < MAX_STATES; s++) begin
      consume_mask[s] = (kind_r[s] == KIND_CONSUME);
    end
  end

  assign negate_mask = negate_r;

endmodule

FILE: hw/rtl/nfarm_expand.sv
// shared expand unit: takes the lowest pending state and adds its successors
module nfarm_expand #(
  parameter int MAX_STATES = nfarm_pkg::NFARM_MAX_STATES
) (
  input  logic [MAX_STATES-1:0]         pend,
  input  logic [MAX_STATES-1:0]         set,
  input  nfarm_pkg::nfarm_xctl_t        ctl,
  output logic [$clog2(MAX_STATES)-1:0] pick,
  input  nfarm_pkg::nfarm_desc_t        desc,
  output logic [MAX_STATES-1:0]         set_nxt,
  output logic [MAX_STATES-1:0]         pend_nxt
);

  import nfarm_pkg::*;

  localparam int IW = $clog2(MAX_STATES);
  localparam logic [MAX_STATES-1:0] ONE = MAX_STATES'(1);

  logic [MAX_STATES-1:0] lowest;
  logic [MAX_STATES-1:0] succ;
  logic [MAX_STATES-1:0] fresh;
  logic                  sel_first;
  logic                  sel_second;

  // isolate and encode the lowest pending state
  assign lowest = pend & (~pend + ONE);

  always_comb begin
    pick = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (lowest[i]) begin
        pick = pick | IW'(i);
      end
    end
  end

  // which successors this state follows
  assign sel_first = ctl.consume_mode
                  || (desc.kind == KIND_EPSILON)
                  || ((desc.kind == KIND_BEGIN) && ctl.pos_zero)
                  || ((desc.kind == KIND_END) && ctl.at_end);
  assign sel_second = !ctl.consume_mode && (desc.kind == KIND_EPSILON);

  // successor codes at or above the state count shift out to nothing
  assign succ = (sel_first  ? (ONE << desc.first)  : '0)
              | (sel_second ? (ONE << desc.second) : '0);
  assign fresh = succ & ~set;

  // consume targets are not expanded further in this pass
  assign set_nxt  = set | succ;
  assign pend_nxt = (pend & ~lowest) | (ctl.consume_mode ? '0 : fresh);

endmodule

FILE: hw/rtl/nfa_regex_matcher.sv
// Table writes do not stall the input. A subject byte runs a closure over the states before the
// consume step, the consume step over the states that consume the byte, and a closure after it.
// An empty subject runs only the closure after the consume step.
// Throughput: one item at a time; the single expand unit handles one state per cycle.
// Reset (rst_n, synchronous): clears the sequencer, active set, match flag and configuration;
// descriptor kinds, successors and class rows are undefined until written; negate flags reset to zero.
module nfa_regex_matcher #(
  parameter int MAX_STATES = nfarm_pkg::NFARM_MAX_STATES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [nfarm_pkg::NFARM_CMD_W-1:0]    in_command,
  input  logic [nfarm_pkg::NFARM_IDX_W-1:0]    in_state_index,
  input  logic [1:0]                           in_state_kind,
  input  logic [nfarm_pkg::NFARM_SUCC_W-1:0]   in_next_first,
  input  logic [nfarm_pkg::NFARM_SUCC_W-1:0]   in_next_second,
  input  logic                                 in_negate,
  input  logic [nfarm_pkg::NFARM_BYTE_W-1:0]   in_class_byte,
  input  logic [nfarm_pkg::NFARM_ROW_W-1:0]    in_class_row,
  input  logic [nfarm_pkg::NFARM_BYTE_W-1:0]   in_subject_byte,
  input  logic                                 in_is_last,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_matched,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nfarm_pkg::NFARM_PADDR_W-1:0]  paddr,
  input  logic [nfarm_pkg::NFARM_DATA_W-1:0]   pwdata,
  output logic [nfarm_pkg::NFARM_DATA_W-1:0]   prdata,
  output logic                                 pready
);

  import nfarm_pkg::*;

  localparam int IW = $clog2(MAX_STATES);
  localparam logic [MAX_STATES-1:0] ONE = MAX_STATES'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE_A,
    S_CONSUME_START,
    S_CONSUME,
    S_CLOSE_B,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MAX_STATES-1:0]   set_r, set_nxt;
  logic [MAX_STATES-1:0]   pend_r, pend_nxt;
  logic [MAX_STATES-1:0]   active_r, active_nxt;
  logic                    pos0_r, pos0_nxt;
  logic                    match_r, match_nxt;
  logic                    last_r, last_nxt;
  logic                    empty_r, empty_nxt;
  nfarm_xctl_t             xctl_r, xctl_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_matched_r, out_matched_nxt;
  logic [NFARM_IDX_W-1:0]  entry_r, entry_nxt;
  logic [NFARM_IDX_W-1:0]  accept_r, accept_nxt;
  logic                    anchored_r, anchored_nxt;

  logic                    in_xfer;
  logic                    cfg_wr;
  nfarm_cmd_t              cmd;
  logic [MAX_STATES-1:0]   entry_bit;
  logic [MAX_STATES-1:0]   accept_bit;
  logic                    hit;
  logic [MAX_STATES-1:0]   class_match;
  logic [NFARM_ROW_W-1:0]  row_q;
  nfarm_desc_t             rd_desc;
  logic [IW-1:0]           pick;
  logic [MAX_STATES-1:0]   consume_mask;
  logic [MAX_STATES-1:0]   negate_mask;
  logic [MAX_STATES-1:0]   x_set_nxt;
  logic [MAX_STATES-1:0]   x_pend_nxt;

  // handshakes
  assign cmd      = nfarm_cmd_t'(in_command);
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // state masks; an index at or above the state count gives no bit
  assign entry_bit  = ONE << entry_r;
  assign accept_bit = ONE << accept_r;
  assign hit        = |(set_r & accept_bit);

  // class test for the current byte, states past the row width are in class only when negated
  assign class_match = MAX_STATES'(row_q) ^ negate_mask;

  // class rows
  nfarm_ram #(
    .WIDTH (NFARM_ROW_W),
    .DEPTH (NFARM_BYTE_VALUES)
  ) u_class_ram (
    .clk     (clk),
    .wr_en   (in_xfer && (cmd == CMD_WR_CLASS)),
    .wr_addr (in_class_byte),
    .wr_data (in_class_row),
    .rd_en   (in_xfer && (cmd == CMD_SUBJECT)),
    .rd_addr (in_subject_byte),
    .rd_data (row_q)
  );

  // state descriptors
  nfarm_desc #(
    .MAX_STATES (MAX_STATES)
  ) u_desc (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (in_xfer && (cmd == CMD_WR_STATE)),
    .wr_idx       (in_state_index),
    .wr_kind      (nfarm_kind_t'(in_state_kind)),
    .wr_first     (in_next_first),
    .wr_second    (in_next_second),
    .wr_negate    (in_negate),
    .rd_idx       (pick),
    .rd_desc      (rd_desc),
    .consume_mask (consume_mask),
    .negate_mask  (negate_mask)
  );

  // shared expand unit
  nfarm_expand #(
    .MAX_STATES (MAX_STATES)
  ) u_expand (
    .pend     (pend_r),
    .set      (set_r),
    .ctl      (xctl_r),
    .pick     (pick),
    .desc     (rd_desc),
    .set_nxt  (x_set_nxt),
    .pend_nxt (x_pend_nxt)
  );

  // configuration read back
  always_comb begin
    case (paddr[3:2])
      REG_ENTRY:    prdata = NFARM_DATA_W'(entry_r);
      REG_ACCEPT:   prdata = NFARM_DATA_W'(accept_r);
      REG_ANCHORED: prdata = NFARM_DATA_W'(anchored_r);
      default:      prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    set_nxt         = set_r;
    pend_nxt        = pend_r;
    active_nxt      = active_r;
    pos0_nxt        = pos0_r;
    match_nxt       = match_r;
    last_nxt        = last_r;
    empty_nxt       = empty_r;
    xctl_nxt        = xctl_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    entry_nxt       = entry_r;
    accept_nxt      = accept_r;
    anchored_nxt    = anchored_r;

    // configuration writes
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENTRY:    entry_nxt    = pwdata[NFARM_IDX_W-1:0];
        REG_ACCEPT:   accept_nxt   = pwdata[NFARM_IDX_W-1:0];
        REG_ANCHORED: anchored_nxt = pwdata[0];
        default:      ;
      endcase
    end

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (cmd)
            CMD_SUBJECT: begin
              last_nxt  = in_is_last;
              empty_nxt = 1'b0;
              if (pos0_r || !anchored_r) begin
                set_nxt   = active_r | entry_bit;
                pend_nxt  = active_r | entry_bit;
                xctl_nxt  = '{consume_mode: 1'b0, pos_zero: pos0_r, at_end: 1'b0};
                state_nxt = S_CLOSE_A;
              end else begin
                set_nxt   = active_r;
                state_nxt = S_CONSUME_START;
              end
            end
            CMD_EMPTY: begin
              set_nxt   = entry_bit;
              pend_nxt  = entry_bit;
              empty_nxt = 1'b1;
              xctl_nxt  = '{consume_mode: 1'b0, pos_zero: 1'b1, at_end: 1'b1};
              state_nxt = S_CLOSE_B;
            end
            default: ;
          endcase
        end
      end
      S_CLOSE_A: begin
        if (pend_r == '0) begin
          state_nxt = S_CONSUME_START;
        end else begin
          set_nxt  = x_set_nxt;
          pend_nxt = x_pend_nxt;
        end
      end
      S_CONSUME_START: begin
        // check the current set, then start building the next one
        match_nxt = match_r | hit;
        pend_nxt  = set_r & consume_mask & class_match;
        set_nxt   = anchored_r ? '0 : entry_bit;
        xctl_nxt  = '{consume_mode: 1'b1, pos_zero: 1'b0, at_end: 1'b0};
        state_nxt = S_CONSUME;
      end
      S_CONSUME: begin
        if (pend_r == '0) begin
          pend_nxt  = set_r;
          xctl_nxt  = '{consume_mode: 1'b0, pos_zero: 1'b0, at_end: last_r};
          state_nxt = S_CLOSE_B;
        end else begin
          set_nxt  = x_set_nxt;
          pend_nxt = x_pend_nxt;
        end
      end
      S_CLOSE_B: begin
        if (pend_r == '0) begin
          if (empty_r) begin
            match_nxt = hit;
            state_nxt = S_EMIT;
          end else begin
            match_nxt = match_r | hit;
            if (last_r) begin
              state_nxt = S_EMIT;
            end else begin
              active_nxt = set_r;
              pos0_nxt   = 1'b0;
              state_nxt  = S_IDLE;
            end
          end
        end else begin
          set_nxt  = x_set_nxt;
          pend_nxt = x_pend_nxt;
        end
      end
      S_EMIT: begin
        // wait for a free output slot, then start a fresh subject
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = match_r;
          active_nxt      = '0;
          pos0_nxt        = 1'b1;
          match_nxt       = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      set_r       <= '0;
      pend_r      <= '0;
      active_r    <= '0;
      pos0_r      <= 1'b1;
      match_r     <= 1'b0;
      last_r      <= 1'b0;
      empty_r     <= 1'b0;
      xctl_r      <= '0;
      out_valid_r <= 1'b0;
      entry_r     <= '0;
      accept_r    <= '0;
      anchored_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      set_r       <= set_nxt;
      pend_r      <= pend_nxt;
      active_r    <= active_nxt;
      pos0_r      <= pos0_nxt;
      match_r     <= match_nxt;
      last_r      <= last_nxt;
      empty_r     <= empty_nxt;
      xctl_r      <= xctl_nxt;
      out_valid_r <= out_valid_nxt;
      entry_r     <= entry_nxt;
      accept_r    <= accept_nxt;
      anchored_r  <= anchored_nxt;
    end
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

FILE: hw/rtl/nfarm_checker.sv
// port-level checks of the nfa regex matcher and their binding
module nfarm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [nfarm_pkg::NFARM_CMD_W-1:0] in_command,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_matched
);

  import nfarm_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_matched)))
    else $error("stalled result changed");

  // a subject byte or empty subject transfer starts a busy period
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_command == CMD_SUBJECT || in_command == CMD_EMPTY)) |=> in_stall)
    else $error("no busy period after subject transfer");

  // table writes do not stall the input
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_command == CMD_WR_STATE || in_command == CMD_WR_CLASS)) |=> !in_stall)
    else $error("table write stalled the input");

  // a new result only comes out of a busy period
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without preceding work");

endmodule

bind nfa_regex_matcher nfarm_checker u_nfarm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_command  (in_command),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_matched (out_matched)
);
